// ----- rtl/cbf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the counting Bloom filter engine
// Sizes, operation and register codes, payload structs, command/status bundles.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int unsigned COUNTER_DEPTH = 65536;
  localparam int unsigned MAX_HASHES    = 10;
  localparam int unsigned COUNTER_BITS  = 8;

  localparam int unsigned ADDR_W  = $clog2(COUNTER_DEPTH);
  localparam int unsigned SIZE_W  = ADDR_W + 1;
  localparam int unsigned K_W     = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned FS_W    = 17;
  localparam int unsigned HC_W    = 4;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // remainder unit: 64-bit dividend, four quotient bits per cycle
  localparam int unsigned DIVD_W    = 64;
  localparam int unsigned MOD_STEP  = 4;
  localparam int unsigned MOD_CYC   = DIVD_W / MOD_STEP;
  localparam int unsigned MOD_CNT_W = $clog2(MOD_CYC);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 2'd1;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [CHAR_W-1:0] key_char;
    logic                     char_valid;
    logic                     key_last;
  } in_item_t;

  typedef struct packed {
    logic [OP_W-1:0] done_operation;
    logic            present;
  } out_item_t;

  typedef struct packed {
    logic                     absorb;
    logic signed [CHAR_W-1:0] key_char;
    logic                     hash_clear;
    logic                     clr_wr;
    logic                     mod_start;
    logic [SIZE_W-1:0]        modulus;
    logic [K_W-1:0]           k;
    logic                     rd_mod;
    logic                     rd_idx;
    logic                     chk;
    logic                     pres_set;
    logic                     upd_wr;
    logic                     upd_inc;
  } cbf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic present;
    logic hit;
  } cbf_status_t;

endpackage
`default_nettype wire

// ----- rtl/cbf_mod.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_mod: iterative remainder unit
// Sign-extends a 32-bit hash to 64 bits and reduces it modulo a 17-bit value,
// four dividend bits per cycle.
// ----------------------------------------------------------------------------
module cbf_mod (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [cbf_pkg::HASH_W-1:0] value_i,
  input  wire logic [cbf_pkg::SIZE_W-1:0] modulus_i,
  output logic                            done_o,
  output logic [cbf_pkg::ADDR_W-1:0]      rem_o
);
  import cbf_pkg::*;

  logic [DIVD_W-1:0]    divd_q, divd_d;
  logic [ADDR_W-1:0]    rem_q, rem_d;
  logic [SIZE_W-1:0]    mod_q;
  logic [MOD_CNT_W-1:0] cnt_q;
  logic                 busy_q, done_q;

  always_comb begin
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(rem_q);
    divd_d = divd_q;
    for (int j = 0; j < MOD_STEP; j++) begin
      r = {r[SIZE_W-2:0], divd_d[DIVD_W-1]};
      divd_d = {divd_d[DIVD_W-2:0], 1'b0};
      if (r >= mod_q) begin
        r = r - mod_q;
      end
    end
    rem_d = r[ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      divd_q <= {{(DIVD_W-HASH_W){value_i[HASH_W-1]}}, value_i};
      rem_q  <= '0;
      mod_q  <= modulus_i;
    end else if (busy_q) begin
      divd_q <= divd_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ----- rtl/cbf_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_dp: datapath of the counting Bloom filter engine
// Hash accumulators, index file, remainder unit and the counter memory.
// ----------------------------------------------------------------------------
module cbf_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cbf_pkg::cbf_cmd_t    cmd_i,
  output cbf_pkg::cbf_status_t      st_o
);
  import cbf_pkg::*;

  logic [HASH_W-1:0]       hash_q [MAX_HASHES];
  logic [HASH_W-1:0]       hash_d [MAX_HASHES];
  logic [ADDR_W-1:0]       idx_q  [MAX_HASHES];
  logic [COUNTER_BITS-1:0] mem_q  [COUNTER_DEPTH];
  logic [COUNTER_BITS-1:0] rdata_q;
  logic [ADDR_W-1:0]       clr_addr_q;
  logic                    present_q;
  logic                    mod_done;
  logic [ADDR_W-1:0]       mod_rem;
  logic [ADDR_W-1:0]       raddr, waddr;
  logic [COUNTER_BITS-1:0] wdata;
  logic                    wen;

  function automatic logic [HASH_W-1:0] hash_rule(int unsigned r, logic [HASH_W-1:0] h,
                                                  logic [HASH_W-1:0] c);
    logic [HASH_W-1:0] a, s;
    a = HASH_W'($signed(h) >>> 5);
    s = h << 5;
    case (r)
      0:       hash_rule = h + c + 32'd31;
      1:       hash_rule = h + HASH_W'(c * 32'd31);
      2:       hash_rule = h + HASH_W'((c + 32'd31) * 32'd11);
      3:       hash_rule = a + c;
      4:       hash_rule = s + c;
      5:       hash_rule = s + a + c;
      6:       hash_rule = h + HASH_W'(c * 32'd11) + 32'd31;
      7:       hash_rule = HASH_W'((s + a) * 32'd11) + c;
      8:       hash_rule = HASH_W'(a * 32'd11) + c;
      default: hash_rule = HASH_W'(s * 32'd11) + c;
    endcase
  endfunction

  always_comb begin
    logic [HASH_W-1:0] c;
    c = {{(HASH_W-CHAR_W){cmd_i.key_char[CHAR_W-1]}}, cmd_i.key_char};
    for (int r = 0; r < MAX_HASHES; r++) begin
      hash_d[r] = hash_rule(r, hash_q[r], c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_HASHES; r++) hash_q[r] <= '0;
      clr_addr_q <= '0;
      present_q  <= 1'b1;
    end else begin
      if (cmd_i.hash_clear) begin
        for (int r = 0; r < MAX_HASHES; r++) hash_q[r] <= '0;
      end else if (cmd_i.absorb) begin
        for (int r = 0; r < MAX_HASHES; r++) hash_q[r] <= hash_d[r];
      end
      if (cmd_i.clr_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.pres_set) begin
        present_q <= 1'b1;
      end else if (cmd_i.chk) begin
        present_q <= st_o.hit;
      end
    end
  end

  cbf_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .value_i   (hash_q[cmd_i.k]),
    .modulus_i (cmd_i.modulus),
    .done_o    (mod_done),
    .rem_o     (mod_rem)
  );

  // latch each index as it is produced
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_mod) idx_q[cmd_i.k] <= mod_rem;
  end

  assign raddr = cmd_i.rd_mod ? mod_rem : idx_q[cmd_i.k];
  assign waddr = cmd_i.clr_wr ? clr_addr_q : idx_q[cmd_i.k];
  assign wdata = cmd_i.clr_wr ? '0 :
                 (cmd_i.upd_inc ? rdata_q + 1'b1 : rdata_q - 1'b1);
  assign wen   = cmd_i.clr_wr | cmd_i.upd_wr;

  always_ff @(posedge clk_i) begin
    if (wen) mem_q[waddr] <= wdata;
    if (cmd_i.rd_mod | cmd_i.rd_idx) rdata_q <= mem_q[raddr];
  end

  assign st_o.clr_last = (clr_addr_q == ADDR_W'(COUNTER_DEPTH - 1));
  assign st_o.mod_done = mod_done;
  assign st_o.present  = present_q;
  assign st_o.hit      = present_q && (rdata_q != '0);

endmodule
`default_nettype wire

// ----- rtl/cbf_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cbf_ctrl: controller of the counting Bloom filter engine
// Sequences clearing, key absorption, the check pass and the update pass;
// holds the configuration registers and the output register.
// ----------------------------------------------------------------------------
module cbf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cbf_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cbf_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cbf_pkg::CFG_W-1:0]     cfg_data_i,
  output cbf_pkg::cbf_cmd_t                  cmd_o,
  input  wire cbf_pkg::cbf_status_t          st_i
);
  import cbf_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_P1_START, S_P1_WAIT, S_P1_CHK, S_P2_RD, S_P2_WR, S_OUT
  } state_e;

  state_e            state_q;
  logic [FS_W-1:0]   fsize_q;
  logic [HC_W-1:0]   hcount_q;
  logic [OP_W-1:0]   op_q;
  logic [K_W-1:0]    k_q;
  logic              out_valid_q;
  out_item_t         out_q;
  logic [HC_W-1:0]   n_eff;
  logic [SIZE_W-1:0] modulus;
  logic              in_acc, k_last, out_free, do_update;

  assign n_eff = (hcount_q > HC_W'(MAX_HASHES)) ? HC_W'(MAX_HASHES) : hcount_q;
  assign modulus = (fsize_q == '0) ? SIZE_W'(1) :
                   (32'(fsize_q) > 32'(COUNTER_DEPTH)) ? SIZE_W'(COUNTER_DEPTH) :
                   SIZE_W'(fsize_q);
  assign k_last    = (HC_W'(k_q) == n_eff - 1'b1);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_update = (op_q == OP_INSERT) || ((op_q == OP_REMOVE) && st_i.hit);

  always_comb begin
    cmd_o          = '0;
    cmd_o.key_char = in_data_i.key_char;
    cmd_o.modulus  = modulus;
    cmd_o.k        = k_q;
    cmd_o.upd_inc  = (op_q == OP_INSERT);
    unique case (state_q)
      S_CLEAR:    cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        cmd_o.absorb   = in_acc && in_data_i.char_valid;
        cmd_o.pres_set = in_acc && in_data_i.key_last;
      end
      S_P1_START: cmd_o.mod_start = 1'b1;
      S_P1_WAIT:  cmd_o.rd_mod = st_i.mod_done;
      S_P1_CHK:   cmd_o.chk = 1'b1;
      S_P2_RD:    cmd_o.rd_idx = 1'b1;
      S_P2_WR:    cmd_o.upd_wr = 1'b1;
      S_OUT:      cmd_o.hash_clear = 1'b1;
      default:    cmd_o.hash_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fsize_q     <= FS_W'(COUNTER_DEPTH);
      hcount_q    <= HC_W'(MAX_HASHES);
      op_q        <= OP_INSERT;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FILTER_SIZE: fsize_q  <= cfg_data_i[FS_W-1:0];
          CFG_HASH_COUNT:  hcount_q <= cfg_data_i[HC_W-1:0];
          default:         ;
        endcase
      end
      if (out_valid_q && !out_stall_i && (state_q != S_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLEAR: if (st_i.clr_last) state_q <= S_IDLE;
        S_IDLE: begin
          if (in_acc && in_data_i.key_last) begin
            op_q    <= in_data_i.operation;
            k_q     <= '0;
            state_q <= (n_eff == '0) ? S_OUT : S_P1_START;
          end
        end
        S_P1_START: state_q <= S_P1_WAIT;
        S_P1_WAIT:  if (st_i.mod_done) state_q <= S_P1_CHK;
        S_P1_CHK: begin
          if (!k_last) begin
            k_q     <= k_q + 1'b1;
            state_q <= S_P1_START;
          end else if (do_update) begin
            k_q     <= '0;
            state_q <= S_P2_RD;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_P2_RD: state_q <= S_P2_WR;
        S_P2_WR: begin
          if (k_last) begin
            state_q <= S_OUT;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_P2_RD;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q          <= 1'b1;
            out_q.done_operation <= op_q;
            out_q.present        <= st_i.present;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- rtl/counting_bloom_filter_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// counting_bloom_filter_engine: streaming counting Bloom filter
// Hashes keys one character at a time and inserts, looks up or removes them
// in a store of 8-bit wrapping counters.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------
//  input    | in        | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//  result   | out       | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  config   | in        | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Characters are accepted while in_stall_o is low. A key end runs a check pass
// over each selected hash (remainder unit start, wait for its done, check),
// then an update pass of a counter read and write per hash on insert or
// accepted remove, and finally loads the result into the output register.
// After reset the 65536 counter entries are cleared one entry per cycle,
// during which in_stall_o stays high; configuration writes are still taken.
// A finished result waits in the output register while new characters transfer;
// the next key's result holds, with the input stalled, until that register
// has been taken.
module counting_bloom_filter_engine (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire cbf_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output cbf_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [cbf_pkg::CFG_W-1:0]     cfg_data_i
);
  import cbf_pkg::*;

  cbf_cmd_t    cmd;
  cbf_status_t st;

  // sequencing, configuration and result register
  cbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  // hashes, index reduction and counter memory
  cbf_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .st_o   (st)
  );

endmodule
`default_nettype wire
